### rtl/core/tcvi_pkg.sv
// Package for the tilt-compensated velocity integrator.
// Holds the sequencer state type, fixed-point constants, the CORDIC arctangent
// table and the rounding and saturation helpers. No dependencies.
package tcvi_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SC_MUL,
    ST_SC_DIV0,
    ST_DIV,
    ST_SC_WR,
    ST_TR_MUL,
    ST_TR_INIT,
    ST_TR_ITER,
    ST_MAC_MUL,
    ST_MAC_ACC,
    ST_IN_MUL,
    ST_IN_DIV0,
    ST_IN_Q1,
    ST_IN_R1,
    ST_IN_Q2,
    ST_IN_WR,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_SQRT,
    ST_DONE
  } state_t;

  localparam logic [15:0]        CNT_PER_G_RST = 16'd17855;
  localparam logic signed [32:0] G_MS2_X100    = 33'sd981;
  localparam logic signed [32:0] DEG256_RAD_Q40 = 33'sd74961321;
  localparam logic signed [33:0] CORDIC_GAIN   = 34'sd652032875;
  localparam logic signed [16:0] QUARTER_TURN  = 17'sd23040;
  localparam logic signed [16:0] HALF_TURN     = 17'sd46080;
  localparam logic [23:0]        MS_PER_S      = 24'd1000;
  // ceil(2^38 / 125): exact floor(y / 125) for y below 2^31
  localparam logic signed [32:0] RECIP_125     = 33'sd2199023256;
  localparam int                 DEN_W         = 23;
  localparam int                 ATAN_ENTRIES  = 24;

  function automatic logic signed [31:0] atan_q30(input logic [4:0] idx);
    logic signed [31:0] r;
    case (idx)
      5'd0:  r = 32'sd843314857;
      5'd1:  r = 32'sd497837829;
      5'd2:  r = 32'sd263043837;
      5'd3:  r = 32'sd133525159;
      5'd4:  r = 32'sd67021687;
      5'd5:  r = 32'sd33543516;
      5'd6:  r = 32'sd16775851;
      5'd7:  r = 32'sd8388437;
      5'd8:  r = 32'sd4194283;
      5'd9:  r = 32'sd2097149;
      5'd10: r = 32'sd1048576;
      5'd11: r = 32'sd524288;
      5'd12: r = 32'sd262144;
      5'd13: r = 32'sd131072;
      5'd14: r = 32'sd65536;
      5'd15: r = 32'sd32768;
      5'd16: r = 32'sd16384;
      5'd17: r = 32'sd8192;
      5'd18: r = 32'sd4096;
      5'd19: r = 32'sd2048;
      5'd20: r = 32'sd1024;
      5'd21: r = 32'sd512;
      5'd22: r = 32'sd256;
      5'd23: r = 32'sd128;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + 64'sd536870912;
    return t >>> 30;
  endfunction

endpackage

### rtl/core/tilt_compensated_velocity_integrator.sv
// Tilt-compensated velocity integrator, top level.
// Sequencer around one shared 33x33 multiplier, a bit-serial divider, an
// iterative CORDIC and a bit-pair square root. Depends on tcvi_pkg.
//
// One input transfer yields one result transfer. The three raw axes are
// scaled to m/s^2 by counts per g, rotated into the earth frame with CORDIC
// sine and cosine of roll and pitch, gravity is removed from z, the result
// times elapsed_ms/1000 is added to three saturating velocity accumulators,
// and the speed is the floor square root of the squared velocities. The
// result appears in the output register as the sequencer returns to idle;
// the bit-serial divider runs three times per item for the scaling, while
// the division by 1000 takes two reciprocal multiplies. in_tready is high
// only while the sequencer is idle. A finished result waits in the output
// register, so the next item may be taken while it waits. cfg_data writes
// counts per g at any time the block is idle; zero acts as one.
module tilt_compensated_velocity_integrator #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // lsb up: accel_x[15:0], accel_y[31:16], accel_z[47:32],
  // roll_angle[64:48], pitch_angle[81:65], elapsed_ms[97:82], zero pad
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,
  // lsb up: earth_accel_x, earth_accel_y, earth_accel_z, velocity_x,
  // velocity_y, velocity_z, speed; 32 bits each
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [223:0] out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);

  localparam int NSTEP = (CORDIC_STEPS > tcvi_pkg::ATAN_ENTRIES) ?
                         tcvi_pkg::ATAN_ENTRIES : CORDIC_STEPS;
  localparam logic [4:0] LAST_STEP = 5'(NSTEP - 1);
  localparam logic signed [63:0] GRAV =
    ((64'sd981 <<< FRAC_BITS) + 64'sd50) / 64'sd100;

  tcvi_pkg::state_t state_r, state_nxt;

  logic [15:0]               cnt_g_r;
  logic signed [15:0]        raw_r [3];
  logic signed [16:0]        roll_r, pitch_r;
  logic [15:0]               ms_r;
  logic [tcvi_pkg::DEN_W-1:0] den_r;
  logic [tcvi_pkg::DEN_W-1:0] dvs_r;
  logic [tcvi_pkg::DEN_W-1:0] rem_r;
  logic [63:0]               quo_r;
  logic [14:0]               qh_r;
  logic                      div_neg_r;
  logic [5:0]                dcnt_r;
  logic [1:0]                k_r;
  logic                      j_r;
  logic [3:0]                u_r;
  logic [4:0]                i_r;
  logic [4:0]                scnt_r;
  logic signed [63:0]        prod_r;
  logic signed [63:0]        acc_r;
  logic signed [31:0]        a_r [3];
  logic signed [31:0]        e_r [3];
  logic signed [31:0]        v_r [3];
  logic signed [32:0]        c_r [2];
  logic signed [32:0]        s_r [2];
  logic signed [32:0]        t_r [4];
  logic signed [33:0]        cx_r, cy_r, cz_r;
  logic                      neg_r;
  logic [63:0]               sum_r, sq_v_r, res_r, bit_r;
  logic [31:0]               speed_r;
  logic                      out_valid_r;
  logic [223:0]              out_data_r;

  logic signed [32:0]        mul_a, mul_b;
  logic signed [65:0]        prod_full;
  logic                      load_out;
  logic                      last_k, last_i, last_d, last_s;

  // input field views
  logic signed [16:0] ang_sel, ang_fold;
  logic               fold_neg;
  logic [15:0]        cnt0;

  assign in_tready  = (state_r == tcvi_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign last_k = (k_r == 2'd2);
  assign last_i = (i_r == LAST_STEP);
  assign last_d = (dcnt_r == 6'd63);
  assign last_s = (scnt_r == 5'd31);
  assign cnt0   = (cnt_g_r == 16'd0) ? 16'd1 : cnt_g_r;

  always_comb begin
    ang_sel  = j_r ? pitch_r : roll_r;
    ang_fold = ang_sel;
    fold_neg = 1'b0;
    if (ang_sel > tcvi_pkg::QUARTER_TURN) begin
      ang_fold = ang_sel - tcvi_pkg::HALF_TURN;
      fold_neg = 1'b1;
    end else if (ang_sel < -tcvi_pkg::QUARTER_TURN) begin
      ang_fold = ang_sel + tcvi_pkg::HALF_TURN;
      fold_neg = 1'b1;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      tcvi_pkg::ST_SC_MUL: begin
        mul_a = 33'(raw_r[k_r]);
        mul_b = tcvi_pkg::G_MS2_X100;
      end
      tcvi_pkg::ST_TR_MUL: begin
        mul_a = 33'(ang_fold);
        mul_b = tcvi_pkg::DEG256_RAD_Q40;
      end
      tcvi_pkg::ST_MAC_MUL: begin
        case (u_r)
          4'd0:  begin mul_a = s_r[0];      mul_b = s_r[1]; end
          4'd1:  begin mul_a = c_r[0];      mul_b = s_r[1]; end
          4'd2:  begin mul_a = s_r[0];      mul_b = c_r[1]; end
          4'd3:  begin mul_a = c_r[0];      mul_b = c_r[1]; end
          4'd4:  begin mul_a = 33'(a_r[0]); mul_b = c_r[1]; end
          4'd5:  begin mul_a = 33'(a_r[1]); mul_b = t_r[0]; end
          4'd6:  begin mul_a = 33'(a_r[2]); mul_b = t_r[1]; end
          4'd7:  begin mul_a = 33'(a_r[1]); mul_b = c_r[0]; end
          4'd8:  begin mul_a = 33'(a_r[2]); mul_b = s_r[0]; end
          4'd9:  begin mul_a = 33'(a_r[0]); mul_b = s_r[1]; end
          4'd10: begin mul_a = 33'(a_r[1]); mul_b = t_r[2]; end
          4'd11: begin mul_a = 33'(a_r[2]); mul_b = t_r[3]; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      tcvi_pkg::ST_IN_MUL: begin
        mul_a = 33'(e_r[k_r]);
        mul_b = $signed({17'd0, ms_r});
      end
      // upper part of the rounded magnitude, divided by 8, times 1/125
      tcvi_pkg::ST_IN_Q1: begin
        mul_a = $signed({12'd0, quo_r[47:27]});
        mul_b = tcvi_pkg::RECIP_125;
      end
      // remainder joined with the low 24 bits, divided by 8, times 1/125
      tcvi_pkg::ST_IN_Q2: begin
        mul_a = $signed({2'd0, quo_r[33:3]});
        mul_b = tcvi_pkg::RECIP_125;
      end
      tcvi_pkg::ST_SQ_MUL: begin
        mul_a = 33'(v_r[k_r]);
        mul_b = 33'(v_r[k_r]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  // next state
  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    case (state_r)
      tcvi_pkg::ST_IDLE:    if (in_tvalid) state_nxt = tcvi_pkg::ST_SC_MUL;
      tcvi_pkg::ST_SC_MUL:  state_nxt = tcvi_pkg::ST_SC_DIV0;
      tcvi_pkg::ST_SC_DIV0: state_nxt = tcvi_pkg::ST_DIV;
      tcvi_pkg::ST_DIV: begin
        if (last_d) state_nxt = tcvi_pkg::ST_SC_WR;
      end
      tcvi_pkg::ST_SC_WR:   state_nxt = last_k ? tcvi_pkg::ST_TR_MUL : tcvi_pkg::ST_SC_MUL;
      tcvi_pkg::ST_TR_MUL:  state_nxt = tcvi_pkg::ST_TR_INIT;
      tcvi_pkg::ST_TR_INIT: state_nxt = tcvi_pkg::ST_TR_ITER;
      tcvi_pkg::ST_TR_ITER: begin
        if (last_i) state_nxt = j_r ? tcvi_pkg::ST_MAC_MUL : tcvi_pkg::ST_TR_MUL;
      end
      tcvi_pkg::ST_MAC_MUL: state_nxt = tcvi_pkg::ST_MAC_ACC;
      tcvi_pkg::ST_MAC_ACC: begin
        state_nxt = (u_r == 4'd11) ? tcvi_pkg::ST_IN_MUL : tcvi_pkg::ST_MAC_MUL;
      end
      tcvi_pkg::ST_IN_MUL:  state_nxt = tcvi_pkg::ST_IN_DIV0;
      tcvi_pkg::ST_IN_DIV0: state_nxt = tcvi_pkg::ST_IN_Q1;
      tcvi_pkg::ST_IN_Q1:   state_nxt = tcvi_pkg::ST_IN_R1;
      tcvi_pkg::ST_IN_R1:   state_nxt = tcvi_pkg::ST_IN_Q2;
      tcvi_pkg::ST_IN_Q2:   state_nxt = tcvi_pkg::ST_IN_WR;
      tcvi_pkg::ST_IN_WR:   state_nxt = last_k ? tcvi_pkg::ST_SQ_MUL : tcvi_pkg::ST_IN_MUL;
      tcvi_pkg::ST_SQ_MUL:  state_nxt = tcvi_pkg::ST_SQ_ACC;
      tcvi_pkg::ST_SQ_ACC:  state_nxt = last_k ? tcvi_pkg::ST_SQRT : tcvi_pkg::ST_SQ_MUL;
      tcvi_pkg::ST_SQRT:    if (last_s) state_nxt = tcvi_pkg::ST_DONE;
      tcvi_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = tcvi_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tcvi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tcvi_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // datapath helpers
  logic signed [63:0] acc_add, acc_sub, num_sc, qs, qi, vsum;
  logic [63:0]        num_abs, qi_mag;
  logic [14:0]        q1_w;
  logic [23:0]        r1_w;
  logic [tcvi_pkg::DEN_W:0] rem2;
  logic               rem_ge;
  logic signed [33:0] atan_e, cx_n, cy_n, cz_n;
  logic [63:0]        sq_t;

  assign acc_add = acc_r + prod_r;
  assign acc_sub = acc_r - prod_r;
  assign num_sc  = (state_r == tcvi_pkg::ST_SC_DIV0) ? (prod_r <<< FRAC_BITS) : prod_r;
  assign num_abs = num_sc[63] ? (64'd0 - 64'(num_sc)) : 64'(num_sc);
  assign qs      = div_neg_r ? -$signed(quo_r) : $signed(quo_r);
  assign q1_w    = prod_r[52:38];
  assign r1_w    = quo_r[47:24] - ({9'd0, q1_w} * tcvi_pkg::MS_PER_S);
  assign qi_mag  = {25'd0, qh_r, prod_r[61:38]};
  assign qi      = div_neg_r ? -$signed(qi_mag) : $signed(qi_mag);
  assign vsum    = 64'(v_r[k_r]) + qi;
  assign rem2    = {rem_r, quo_r[63]};
  assign rem_ge  = (rem2 >= {1'b0, dvs_r});
  assign atan_e  = 34'(tcvi_pkg::atan_q30(i_r));
  assign sq_t    = res_r + bit_r;

  always_comb begin
    if (!cz_r[33]) begin
      cx_n = cx_r - (cy_r >>> i_r);
      cy_n = cy_r + (cx_r >>> i_r);
      cz_n = cz_r - atan_e;
    end else begin
      cx_n = cx_r + (cy_r >>> i_r);
      cy_n = cy_r - (cx_r >>> i_r);
      cz_n = cz_r + atan_e;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_g_r     <= tcvi_pkg::CNT_PER_G_RST;
      v_r[0]      <= '0;
      v_r[1]      <= '0;
      v_r[2]      <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      j_r         <= 1'b0;
      u_r         <= '0;
      i_r         <= '0;
      dcnt_r      <= '0;
      scnt_r      <= '0;
    end else begin
      if (cfg_valid) cnt_g_r <= cfg_data;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      case (state_r)
        tcvi_pkg::ST_SC_MUL, tcvi_pkg::ST_TR_MUL, tcvi_pkg::ST_MAC_MUL,
        tcvi_pkg::ST_IN_MUL, tcvi_pkg::ST_IN_Q1, tcvi_pkg::ST_IN_Q2,
        tcvi_pkg::ST_SQ_MUL: prod_r <= prod_full[63:0];
        default: ;
      endcase

      case (state_r)
        tcvi_pkg::ST_IDLE: begin
          if (in_tvalid) begin
            raw_r[0] <= $signed(in_tdata[15:0]);
            raw_r[1] <= $signed(in_tdata[31:16]);
            raw_r[2] <= $signed(in_tdata[47:32]);
            roll_r   <= $signed(in_tdata[64:48]);
            pitch_r  <= $signed(in_tdata[81:65]);
            ms_r     <= in_tdata[97:82];
            den_r    <= {1'b0, cnt0, 6'd0} + {2'd0, cnt0, 5'd0} + {5'd0, cnt0, 2'd0};
            k_r      <= '0;
          end
        end
        tcvi_pkg::ST_SC_DIV0: begin
          dvs_r     <= den_r;
          div_neg_r <= num_sc[63];
          quo_r     <= num_abs + 64'(den_r >> 1);
          rem_r     <= '0;
          dcnt_r    <= '0;
        end
        tcvi_pkg::ST_DIV: begin
          rem_r  <= rem_ge ? tcvi_pkg::DEN_W'(rem2 - {1'b0, dvs_r})
                           : tcvi_pkg::DEN_W'(rem2);
          quo_r  <= {quo_r[62:0], rem_ge};
          dcnt_r <= dcnt_r + 6'd1;
        end
        tcvi_pkg::ST_SC_WR: begin
          a_r[k_r] <= tcvi_pkg::sat32(qs);
          k_r      <= last_k ? 2'd0 : k_r + 2'd1;
          j_r      <= 1'b0;
        end
        tcvi_pkg::ST_TR_MUL: neg_r <= fold_neg;
        tcvi_pkg::ST_TR_INIT: begin
          cx_r <= tcvi_pkg::CORDIC_GAIN;
          cy_r <= '0;
          cz_r <= 34'((prod_r + 64'sd512) >>> 10);
          i_r  <= '0;
        end
        tcvi_pkg::ST_TR_ITER: begin
          cx_r <= cx_n;
          cy_r <= cy_n;
          cz_r <= cz_n;
          i_r  <= i_r + 5'd1;
          if (last_i) begin
            c_r[j_r] <= neg_r ? 33'(-cx_n) : 33'(cx_n);
            s_r[j_r] <= neg_r ? 33'(-cy_n) : 33'(cy_n);
            j_r      <= 1'b1;
            u_r      <= '0;
          end
        end
        tcvi_pkg::ST_MAC_ACC: begin
          u_r <= u_r + 4'd1;
          case (u_r)
            4'd0, 4'd1, 4'd2, 4'd3: t_r[u_r[1:0]] <= 33'(tcvi_pkg::rnd30(prod_r));
            4'd4, 4'd7, 4'd9: acc_r <= prod_r;
            4'd5:  acc_r <= acc_add;
            4'd6:  e_r[0] <= tcvi_pkg::sat32(tcvi_pkg::rnd30(acc_sub));
            4'd8:  e_r[1] <= tcvi_pkg::sat32(tcvi_pkg::rnd30(acc_add));
            4'd10: acc_r <= acc_sub;
            4'd11: begin
              e_r[2] <= tcvi_pkg::sat32(tcvi_pkg::rnd30(acc_add) - GRAV);
              k_r    <= '0;
            end
            default: ;
          endcase
        end
        // magnitude plus half of 1000, split for the reciprocal divide
        tcvi_pkg::ST_IN_DIV0: begin
          div_neg_r <= num_sc[63];
          quo_r     <= num_abs + 64'd500;
        end
        tcvi_pkg::ST_IN_R1: begin
          qh_r  <= q1_w;
          quo_r <= {30'd0, r1_w[9:0], quo_r[23:0]};
        end
        tcvi_pkg::ST_IN_WR: begin
          v_r[k_r] <= tcvi_pkg::sat32(vsum);
          k_r      <= last_k ? 2'd0 : k_r + 2'd1;
        end
        tcvi_pkg::ST_SQ_ACC: begin
          sum_r <= ((k_r == 2'd0) ? 64'd0 : sum_r) + 64'(prod_r);
          k_r   <= last_k ? 2'd0 : k_r + 2'd1;
          if (last_k) begin
            sq_v_r <= sum_r + 64'(prod_r);
            res_r  <= '0;
            bit_r  <= 64'd1 << 62;
            scnt_r <= '0;
          end
        end
        tcvi_pkg::ST_SQRT: begin
          if (sq_v_r >= sq_t) begin
            sq_v_r <= sq_v_r - sq_t;
            res_r  <= (res_r >> 1) + bit_r;
          end else begin
            res_r  <= res_r >> 1;
          end
          bit_r  <= bit_r >> 2;
          scnt_r <= scnt_r + 5'd1;
          if (last_s) speed_r <= (sq_v_r >= sq_t) ? 32'((res_r >> 1) + bit_r)
                                                  : 32'(res_r >> 1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {speed_r, v_r[2], v_r[1], v_r[0], e_r[2], e_r[1], e_r[0]};
    end
  end

endmodule

### bench/tilt_compensated_velocity_integrator_tb.sv
// Testbench for tilt_compensated_velocity_integrator: drives accelerometer
// samples and counts-per-g writes, predicts every result in place and checks
// it field by field. Depends on the RTL top level and tcvi_pkg.
`timescale 1ns / 1ps

module tilt_compensated_velocity_integrator_tb;

  localparam longint RUN_LIMIT     = 3000000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [223:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;

  tilt_compensated_velocity_integrator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [15:0]  counts_per_g = tcvi_pkg::CNT_PER_G_RST;
  logic signed [31:0] vel_x = 0, vel_y = 0, vel_z = 0;
  logic [223:0] expected_results[$];
  int           mismatches = 0;
  int           burst_left = 0;
  int           hold_requests = 0;
  int           holds_served = 0;
  int           hold_left = 0;
  int           rx_mode = 0;
  longint       cycles = 0;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_q30(longint v);
    return (v + 64'sd536870912) >>> 30;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint div_nearest(longint n, longint d);
    logic [63:0] m, q;
    m = (n < 0) ? -n : n;
    q = (m + d / 2) / d;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  task automatic sin_cos(input longint ang, output longint c, output longint s);
    bit     flip;
    longint x, y, z, nx;
    flip = 0;
    x = tcvi_pkg::CORDIC_GAIN;
    y = 0;
    if (ang > tcvi_pkg::QUARTER_TURN) begin
      ang -= tcvi_pkg::HALF_TURN;
      flip = 1;
    end else if (ang < -tcvi_pkg::QUARTER_TURN) begin
      ang += tcvi_pkg::HALF_TURN;
      flip = 1;
    end
    z = asr(ang * tcvi_pkg::DEG256_RAD_Q40 + 512, 10);
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - asr(y, i);
        y = y + asr(x, i);
        z -= tcvi_pkg::atan_q30(5'(i));
      end else begin
        nx = x + asr(y, i);
        y = y - asr(x, i);
        z += tcvi_pkg::atan_q30(5'(i));
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] add_step(logic signed [31:0] v, longint a,
                                                  longint ms);
    return 32'(clamp32(longint'(v) + div_nearest(a * ms, 1000)));
  endfunction

  task automatic predict_sample(input logic [103:0] d);
    longint cnt, scale, g, ax, ay, az, ms, cr, sr, cp, sp;
    longint srsp, crsp, srcp, crcp, ex, ey, ez, vx, vy, vz;
    logic [63:0] sq, spd;
    cnt = (counts_per_g == 0) ? 1 : counts_per_g;
    scale = 981 * 65536;
    g = div_nearest(scale, 100);
    ax = clamp32(div_nearest(longint'($signed(d[15:0])) * scale, 100 * cnt));
    ay = clamp32(div_nearest(longint'($signed(d[31:16])) * scale, 100 * cnt));
    az = clamp32(div_nearest(longint'($signed(d[47:32])) * scale, 100 * cnt));
    ms = d[97:82];
    sin_cos(longint'($signed(d[64:48])), cr, sr);
    sin_cos(longint'($signed(d[81:65])), cp, sp);
    srsp = round_q30(sr * sp);
    crsp = round_q30(cr * sp);
    srcp = round_q30(sr * cp);
    crcp = round_q30(cr * cp);
    ex = clamp32(round_q30(ax * cp + ay * srsp - az * crsp));
    ey = clamp32(round_q30(ay * cr + az * sr));
    ez = clamp32(round_q30(ax * sp - ay * srcp + az * crcp) - g);
    vel_x = add_step(vel_x, ex, ms);
    vel_y = add_step(vel_y, ey, ms);
    vel_z = add_step(vel_z, ez, ms);
    vx = vel_x;
    vy = vel_y;
    vz = vel_z;
    sq = 64'(vx * vx) + 64'(vy * vy) + 64'(vz * vz);
    spd = floor_sqrt(sq);
    if (spd > 64'hFFFFFFFF) spd = 64'hFFFFFFFF;
    expected_results.push_back({spd[31:0], vz[31:0], vy[31:0], vx[31:0],
                                ez[31:0], ey[31:0], ex[31:0]});
  endtask

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin
    logic [223:0] want;
    string names[7];
    names = '{"earth_accel_x", "earth_accel_y", "earth_accel_z", "velocity_x",
              "velocity_y", "velocity_z", "speed"};
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report("unexpected transfer", out_tdata[31:0], 32'd0);
      end else begin
        want = expected_results.pop_front();
        for (int f = 0; f < 7; f++)
          if (out_tdata[32*f +: 32] !== want[32*f +: 32])
            report(names[f], out_tdata[32*f +: 32], want[32*f +: 32]);
      end
    end
  end

  // receiver stall pattern and long hold-off
  always @(posedge clk) begin
    if (hold_left == 0 && holds_served < hold_requests) begin
      holds_served++;
      hold_left = 4000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) rx_mode = $urandom_range(0, 2);
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z, input logic [16:0] roll,
                             input logic [16:0] pitch, input logic [15:0] ms);
    logic [103:0] d;
    int gap;
    d = {6'd0, ms, pitch, roll, z, y, x};
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_sample(d);
  endtask

  task automatic drain_and_idle;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic set_counts_per_g(input logic [15:0] v);
    drain_and_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    counts_per_g = v;
  endtask

  function automatic logic [16:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return 17'($urandom);
      default: return 17'($signed($urandom_range(0, 92160)) - 46080);
    endcase
  endfunction

  task automatic test_directed;
    logic [16:0] angs[10];
    angs = '{17'sd0, 17'sd23040, -17'sd23040, 17'sd23041, -17'sd23041, 17'sd46080,
             -17'sd46080, 17'h0FFFF, 17'h10000, 17'sd11520};
    for (int i = 0; i < 10; i++)
      send_sample(16'(1000 * i - 4000), 16'sh7FFF, 16'sh8000, angs[i],
                  angs[9 - i], 16'd10);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 17'sd0, 17'sd0, 16'd0);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 17'sd0, 17'sd0, 16'hFFFF);
    send_sample(16'sd0, 16'sd0, 16'sd17855, 17'sd0, 17'sd0, 16'd1);
    send_sample(16'hFFFF, 16'h5555, 16'hAAAA, 17'h15555, 17'h0AAAA, 16'h5555);
    send_sample(16'h0000, 16'hAAAA, 16'h5555, 17'h0AAAA, 17'h15555, 16'hAAAA);
  endtask

  // tiny counts per g and long steps drive the accumulators into saturation
  task automatic test_saturation(input logic [15:0] cnt);
    set_counts_per_g(cnt);
    for (int i = 0; i < 6; i++)
      send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 17'sd0, 17'sd0, 16'hFFFF);
    for (int i = 0; i < 6; i++)
      send_sample(16'sh8000, 16'sh8000, 16'sh8000, 17'sd0, 17'sd0, 16'hFFFF);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_sample(16'($urandom), 16'($urandom), 16'($urandom), rand_angle(),
                    rand_angle(), 16'($urandom));
      else
        send_sample(16'($signed($urandom_range(0, 8000)) - 4000),
                    16'($signed($urandom_range(0, 8000)) - 4000),
                    16'($signed($urandom_range(0, 8000)) + 13000), rand_angle(),
                    rand_angle(), 16'($urandom_range(0, 50)));
    end
  endtask

  task automatic test_backpressure;
    hold_requests++;
    test_random(12);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_saturation(16'd0);
    test_saturation(16'd1);
    set_counts_per_g(16'hFFFF);
    test_random(60);
    set_counts_per_g(16'd16384);
    test_random(150);
    test_backpressure();
    set_counts_per_g(tcvi_pkg::CNT_PER_G_RST);
    test_random(200);
    set_counts_per_g(16'($urandom_range(1, 65535)));
    test_random(130);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
